### hw/rtl/lbm_pkg.sv
// shared types and constants of the led bar level meter
`default_nettype none

package lbm_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // register field widths
    localparam int COEFF_W = 10;
    localparam int TICKS_W = 8;
    localparam int FLOOR_W = 10;

    // fixed result field widths
    localparam int LED_W       = 12;
    localparam int LEVEL_OUT_W = 4;
    localparam int VALUE_OUT_W = 10;

    // filter weight is Q10
    localparam int COEFF_FRAC = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_DECAY_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_FLOOR        = 3'd4;

    // register reset values
    localparam logic [COEFF_W-1:0] RST_FILTER_COEFF      = 10'd658;
    localparam logic [TICKS_W-1:0] RST_LIGHT_DECAY_TICKS = 8'd21;
    localparam logic [TICKS_W-1:0] RST_PEAK_DECAY_TICKS  = 8'd8;
    localparam logic               RST_PEAK_DECAY_ENABLE = 1'b1;
    localparam logic [FLOOR_W-1:0] RST_PEAK_FLOOR        = 10'd13;

    // opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // tick counters saturate here
    localparam logic [TICKS_W-1:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [COEFF_W-1:0] filter_coeff;
        logic [TICKS_W-1:0] light_decay_ticks;
        logic [TICKS_W-1:0] peak_decay_ticks;
        logic               peak_decay_enable;
        logic [FLOOR_W-1:0] peak_floor;
    } cfg_t;

    // one request being applied to the state this cycle
    typedef struct packed {
        logic en;
        logic op;
    } step_t;

endpackage

`default_nettype wire

### hw/rtl/lbm_if.sv
// request channels of the led bar level meter: items, results, configuration
`default_nettype none

interface lbm_item_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface lbm_result_if;
    logic                               valid;
    logic                               ready;
    logic [lbm_pkg::LED_W-1:0]          led_bar;
    logic [lbm_pkg::LEVEL_OUT_W-1:0]    shown_level;
    logic [lbm_pkg::LEVEL_OUT_W-1:0]    raw_level;
    logic [lbm_pkg::VALUE_OUT_W-1:0]    peak_value;
    logic [lbm_pkg::VALUE_OUT_W-1:0]    filtered_value;

    modport source (output valid, output led_bar, output shown_level, output raw_level,
                    output peak_value, output filtered_value, input ready);
    modport sink   (input valid, input led_bar, input shown_level, input raw_level,
                    input peak_value, input filtered_value, output ready);
endinterface

interface lbm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lbm_pkg::CFG_IDX_W-1:0]   index;
    logic [lbm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/lbm_cfg_regs.sv
// configuration register file of the led bar level meter
`default_nettype none

module lbm_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [lbm_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [lbm_pkg::CFG_DATA_W-1:0] wr_data,
    output lbm_pkg::cfg_t                      cfg
);

    lbm_pkg::cfg_t cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_coeff      <= lbm_pkg::RST_FILTER_COEFF;
            cfg_reg.light_decay_ticks <= lbm_pkg::RST_LIGHT_DECAY_TICKS;
            cfg_reg.peak_decay_ticks  <= lbm_pkg::RST_PEAK_DECAY_TICKS;
            cfg_reg.peak_decay_enable <= lbm_pkg::RST_PEAK_DECAY_ENABLE;
            cfg_reg.peak_floor        <= lbm_pkg::RST_PEAK_FLOOR;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                lbm_pkg::REG_FILTER_COEFF:
                    cfg_reg.filter_coeff <= wr_data[lbm_pkg::COEFF_W-1:0];
                lbm_pkg::REG_LIGHT_DECAY_TICKS:
                    cfg_reg.light_decay_ticks <= wr_data[lbm_pkg::TICKS_W-1:0];
                lbm_pkg::REG_PEAK_DECAY_TICKS:
                    cfg_reg.peak_decay_ticks <= wr_data[lbm_pkg::TICKS_W-1:0];
                lbm_pkg::REG_PEAK_DECAY_ENABLE:
                    cfg_reg.peak_decay_enable <= wr_data[0];
                lbm_pkg::REG_PEAK_FLOOR:
                    cfg_reg.peak_floor <= wr_data[lbm_pkg::FLOOR_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hw/rtl/lbm_filter.sv
// low-pass filter state and latest raw sample
`default_nettype none

module lbm_filter #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lbm_pkg::step_t                    step,
    input  wire logic [SAMPLE_BITS-1:0]            sample,
    input  wire logic [lbm_pkg::COEFF_W-1:0]       coeff,
    output logic      [SAMPLE_BITS-1:0]            acc,
    output logic      [SAMPLE_BITS-1:0]            last_sample,
    output logic      [SAMPLE_BITS-1:0]            acc_after
);

    localparam int PROD_W = SAMPLE_BITS + lbm_pkg::COEFF_W + 2;

    logic        [SAMPLE_BITS-1:0]       acc_reg;
    logic        [SAMPLE_BITS-1:0]       acc_next;
    logic        [SAMPLE_BITS-1:0]       last_reg;
    logic signed [SAMPLE_BITS:0]         diff;
    logic signed [lbm_pkg::COEFF_W:0]    coeff_s;
    logic signed [PROD_W-1:0]            prod;
    logic signed [PROD_W-1:0]            prod_sh;
    logic signed [SAMPLE_BITS+1:0]       sum;
    logic                                take;

    assign take = step.en && (step.op == lbm_pkg::OP_SAMPLE);

    // c*acc + (1-c)*s == s + c*(acc - s), floor of the Q10 product
    always_comb
    begin
        diff    = $signed({1'b0, acc_reg}) - $signed({1'b0, sample});
        coeff_s = $signed({1'b0, coeff});
        prod    = diff * coeff_s;
        prod_sh = prod >>> lbm_pkg::COEFF_FRAC;
        sum     = $signed({2'b00, sample}) + $signed(prod_sh[SAMPLE_BITS+1:0]);
        acc_next = take ? sum[SAMPLE_BITS-1:0] : acc_reg;
    end

    // filter and sample state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            last_reg <= '0;
        end
        else if (take)
        begin
            acc_reg  <= acc_next;
            last_reg <= sample;
        end
    end

    assign acc         = acc_reg;
    assign last_sample = last_reg;
    assign acc_after   = acc_next;

endmodule

`default_nettype wire

### hw/rtl/lbm_meter.sv
// peak hold with decay, level quantizer and shown level with hold
`default_nettype none

module lbm_meter #(
    parameter int SAMPLE_BITS = 10,
    parameter int NUM_LEVELS  = 13
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lbm_pkg::step_t                step,
    input  wire lbm_pkg::cfg_t                 cfg,
    input  wire logic [SAMPLE_BITS-1:0]        filt,
    input  wire logic [SAMPLE_BITS-1:0]        last_sample,
    output logic      [SAMPLE_BITS-1:0]        peak_after,
    output logic      [$clog2(NUM_LEVELS+1)-1:0] level_after,
    output logic      [$clog2(NUM_LEVELS+1)-1:0] shown_after
);

    localparam int LW    = $clog2(NUM_LEVELS + 1);
    localparam int PW    = SAMPLE_BITS + LW;
    localparam int CMP_W = (SAMPLE_BITS > lbm_pkg::FLOOR_W) ? SAMPLE_BITS : lbm_pkg::FLOOR_W;

    logic [SAMPLE_BITS-1:0]       peak_reg, peak_next, peak_dec;
    logic [lbm_pkg::TICKS_W-1:0]  peak_cnt_reg, peak_cnt_next, peak_cnt_inc;
    logic [lbm_pkg::TICKS_W-1:0]  hold_cnt_reg, hold_cnt_next, hold_cnt_inc;
    logic [LW-1:0]                level_reg, level_next, level_calc;
    logic [LW-1:0]                shown_reg, shown_next;
    logic [PW-1:0]                filt_scaled;
    logic [LW-1:0]                hits;
    logic                         tick;

    assign tick = step.en && (step.op == lbm_pkg::OP_TICK);

    // peak decay, then raise to the latest sample
    always_comb
    begin
        peak_cnt_inc = (peak_cnt_reg < lbm_pkg::COUNT_MAX) ? peak_cnt_reg + 1'b1
                                                            : lbm_pkg::COUNT_MAX;
        peak_dec      = peak_reg;
        peak_cnt_next = peak_cnt_reg;
        if (cfg.peak_decay_enable)
        begin
            peak_cnt_next = peak_cnt_inc;
            if (peak_cnt_inc > cfg.peak_decay_ticks)
            begin
                if (CMP_W'(peak_reg) > CMP_W'(cfg.peak_floor))
                    peak_dec = peak_reg - 1'b1;
                peak_cnt_next = '0;
            end
        end
        peak_next = (last_sample > peak_dec) ? last_sample : peak_dec;
    end

    // level: count thresholds k with peak*k < filt*N, which means filt > floor(peak*k/N)
    always_comb
    begin
        filt_scaled = PW'(filt) * PW'(NUM_LEVELS);
        hits = '0;
        for (int k = 1; k < NUM_LEVELS; k++)
        begin
            if (PW'(peak_next) * PW'(k) < filt_scaled)
                hits = hits + 1'b1;
        end
        level_calc = hits + 1'b1;
    end

    // fast attack, slow decay of the shown level
    always_comb
    begin
        hold_cnt_inc = (hold_cnt_reg < lbm_pkg::COUNT_MAX) ? hold_cnt_reg + 1'b1
                                                            : lbm_pkg::COUNT_MAX;
        hold_cnt_next = hold_cnt_inc;
        shown_next    = shown_reg;
        if (level_calc > shown_reg)
        begin
            shown_next    = (level_calc > LW'(NUM_LEVELS)) ? LW'(NUM_LEVELS) : level_calc;
            hold_cnt_next = '0;
        end
        else if (hold_cnt_inc > cfg.light_decay_ticks)
        begin
            if (shown_reg > LW'(1))
                shown_next = shown_reg - 1'b1;
            hold_cnt_next = '0;
        end
        level_next = level_calc;
    end

    // meter state, advanced by tick requests only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg     <= '0;
            peak_cnt_reg <= '0;
            hold_cnt_reg <= '0;
            level_reg    <= LW'(1);
            shown_reg    <= LW'(1);
        end
        else if (tick)
        begin
            peak_reg     <= peak_next;
            peak_cnt_reg <= peak_cnt_next;
            hold_cnt_reg <= hold_cnt_next;
            level_reg    <= level_next;
            shown_reg    <= shown_next;
        end
    end

    assign peak_after  = tick ? peak_next  : peak_reg;
    assign level_after = tick ? level_next : level_reg;
    assign shown_after = tick ? shown_next : shown_reg;

    // shown level stays within 1..NUM_LEVELS
    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        (shown_reg >= LW'(1)) && (shown_reg <= LW'(NUM_LEVELS)))
        else $error("shown level out of range");

    // quantized level stays within 1..NUM_LEVELS
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg >= LW'(1)) && (level_reg <= LW'(NUM_LEVELS)))
        else $error("raw level out of range");

    // a sample request leaves the peak, the shown level and the hold count alone
    a_sample_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (step.en && (step.op == lbm_pkg::OP_SAMPLE)) |=>
        ($stable(peak_reg) && $stable(shown_reg) && $stable(hold_cnt_reg)))
        else $error("sample request changed meter state");

    // a rise of the shown level restarts the hold count
    a_attack_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && (level_calc > shown_reg)) |=> (hold_cnt_reg == '0))
        else $error("hold count not cleared on attack");

endmodule

`default_nettype wire

### hw/rtl/led_bar_level_meter.sv
// top level of the led bar level meter
`default_nettype none

// Level meter for a 12-LED bar. Sample requests (opcode 0) feed a Q10 first-order
// low-pass filter and store the raw sample; tick requests (opcode 1) decay and raise
// the peak, quantize the filtered value against fractions of the peak and update the
// shown level (instant rise, stepped fall after the hold count). Every request gives
// exactly one result carrying the state after it. One request is taken per clock
// unless a stalled result has filled both registers; a result passes through the
// input register and the result register around the combinational state update
// (one filter multiply, or the peak update and level compares). A stalled result
// does not stop the input side until both the input and result registers are
// full. Configuration writes are taken every cycle and must be made while the
// meter is idle. No clearing pass after reset.
module led_bar_level_meter #(
    parameter int SAMPLE_BITS = 10,
    parameter int NUM_LEVELS  = 13
) (
    input wire logic     clk,
    input wire logic     rst_n,
    lbm_item_if.sink     item,
    lbm_result_if.source result,
    lbm_cfg_if.sink      cfg
);

    localparam int LW  = $clog2(NUM_LEVELS + 1);
    localparam int LVW = (LW > lbm_pkg::LEVEL_OUT_W) ? LW : lbm_pkg::LEVEL_OUT_W;
    localparam int VW  = (SAMPLE_BITS > lbm_pkg::VALUE_OUT_W) ? SAMPLE_BITS
                                                               : lbm_pkg::VALUE_OUT_W;

    lbm_pkg::cfg_t            cfg_vals;
    lbm_pkg::step_t           step;

    logic                     in_valid_reg;
    logic                     op_reg;
    logic [SAMPLE_BITS-1:0]   sample_reg;
    logic                     advance;

    logic [SAMPLE_BITS-1:0]   filt_acc, filt_last, filt_after;
    logic [SAMPLE_BITS-1:0]   peak_after;
    logic [LW-1:0]            level_after, shown_after;
    logic [LVW-1:0]           shown_ext, level_ext;
    logic [VW-1:0]            peak_ext, filt_ext;
    logic [lbm_pkg::LED_W-1:0] led_next;

    logic                               out_valid_reg;
    logic [lbm_pkg::LED_W-1:0]          led_reg;
    logic [lbm_pkg::LEVEL_OUT_W-1:0]    shown_out_reg, level_out_reg;
    logic [lbm_pkg::VALUE_OUT_W-1:0]    peak_out_reg, filt_out_reg;

    // configuration registers
    assign cfg.ready = 1'b1;

    lbm_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_vals)
    );

    // input register and flow control
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign step.en    = advance;
    assign step.op    = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            op_reg     <= item.opcode;
            sample_reg <= item.sample;
        end
    end

    // state update
    lbm_filter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_filter (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .sample      (sample_reg),
        .coeff       (cfg_vals.filter_coeff),
        .acc         (filt_acc),
        .last_sample (filt_last),
        .acc_after   (filt_after)
    );

    lbm_meter #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_meter (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .cfg         (cfg_vals),
        .filt        (filt_acc),
        .last_sample (filt_last),
        .peak_after  (peak_after),
        .level_after (level_after),
        .shown_after (shown_after)
    );

    // result fields at their fixed widths, thermometer code of the shown level
    always_comb
    begin
        shown_ext = LVW'(shown_after);
        level_ext = LVW'(level_after);
        peak_ext  = VW'(peak_after);
        filt_ext  = VW'(filt_after);
        for (int i = 0; i < lbm_pkg::LED_W; i++)
            led_next[i] = (shown_ext > LVW'(i + 1));
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            led_reg       <= led_next;
            shown_out_reg <= shown_ext[lbm_pkg::LEVEL_OUT_W-1:0];
            level_out_reg <= level_ext[lbm_pkg::LEVEL_OUT_W-1:0];
            peak_out_reg  <= peak_ext[lbm_pkg::VALUE_OUT_W-1:0];
            filt_out_reg  <= filt_ext[lbm_pkg::VALUE_OUT_W-1:0];
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.led_bar        = led_reg;
    assign result.shown_level    = shown_out_reg;
    assign result.raw_level      = level_out_reg;
    assign result.peak_value     = peak_out_reg;
    assign result.filtered_value = filt_out_reg;

endmodule

`default_nettype wire
